@@ sv/pkt_pkg.sv @@
package pkt_pkg;

	// Widths of the item fields on the ports.
	localparam int OP_W        = 3;
	localparam int DATA_W      = 64;
	localparam int AUTH_W      = 128;
	localparam int ADDR_PORT_W = 16;

	// Operation codes carried by the operation field.
	typedef enum logic [OP_W-1:0] {
		OP_ADD_NODE  = 3'd0,
		OP_DROP_NODE = 3'd1,
		OP_ADD_WEAK  = 3'd2,
		OP_DROP_WEAK = 3'd3,
		OP_AUTH_LKUP = 3'd4,
		OP_ADDR_LKUP = 3'd5,
		OP_KEY_LKUP  = 3'd6,
		OP_VALIDATE  = 3'd7
	} op_t;

endpackage

@@ sv/peer_key_table_unit.sv @@
// Channel   Handshake             Payload
// request   req_valid/req_ready   operation, serial_in, auth_upper, auth_lower, key_in,
//                                 peer_address
// response  rsp_valid/rsp_ready   success, serial_out, key_out
//
// Each item is handled by one scan over the entries, one entry a cycle through the table
// memories' single read port; a key lookup then reads the node serial a second time.
// The next item is taken in the cycle after the result is loaded.
// Reset frees every table entry at once; no clearing pass is needed.
// A stalled response holds in the output register while the next item is accepted.
module peer_key_table_unit import pkt_pkg::*; #(
	parameter int ENTRIES      = 16,
	parameter int SERIAL_BYTES = 8,
	parameter int KEY_BYTES    = 8,
	parameter int ADDR_BITS    = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_ready,
	input  logic [OP_W-1:0]        operation,
	input  logic [DATA_W-1:0]      serial_in,
	input  logic [DATA_W-1:0]      auth_upper,
	input  logic [DATA_W-1:0]      auth_lower,
	input  logic [DATA_W-1:0]      key_in,
	input  logic [ADDR_PORT_W-1:0] peer_address,
	output logic                   rsp_valid,
	input  logic                   rsp_ready,
	output logic                   success,
	output logic [DATA_W-1:0]      serial_out,
	output logic [DATA_W-1:0]      key_out
);

	localparam int IW    = $clog2(ENTRIES);
	localparam int CW    = $clog2(ENTRIES + 1);
	localparam int SER_W = 8 * SERIAL_BYTES;
	localparam int KEY_W = 8 * KEY_BYTES;
	localparam int ADR_W = (ADDR_BITS < ADDR_PORT_W) ? ADDR_BITS : ADDR_PORT_W;
	localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
	localparam logic [CW-1:0] SCAN_END = CW'(ENTRIES);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_SCAN   = 5'b00010,
		S_FETCH  = 5'b00100,
		S_COMMIT = 5'b01000,
		S_DONE   = 5'b10000
	} state_t;

	state_t              state_q;
	op_t                 op_q;
	logic [SER_W-1:0]    sn_q;
	logic [AUTH_W-1:0]   auth_q;
	logic [KEY_W-1:0]    key_q;
	logic [ADR_W-1:0]    addr_q;
	logic [CW-1:0]       rd_cnt_q;
	logic                chk_valid_q;
	logic [IW-1:0]       chk_idx_q;
	logic                hit_a_q, hit_b_q, hit_c_q;
	logic [IW-1:0]       idx_a_q, idx_b_q, idx_c_q;
	logic [IW-1:0]       nidx_q;
	logic [DATA_W-1:0]   data_q;
	logic [ENTRIES-1:0]  node_used_q, node_val_q, weak_used_q, peer_used_q;
	logic                rsp_valid_q;
	logic                success_q;
	logic [DATA_W-1:0]   serial_out_q, key_out_q;

	logic                accept, scan_issue, check, scan_last, load_rsp, all_hit;
	logic [IW-1:0]       scan_addr, serial_raddr, paddr_waddr;
	logic                n_used, n_val, w_used, p_used;
	logic                sn_eq, auth_eq, waddr_eq, wkey_eq, paddr_eq, pkey_eq;
	logic                cond_a, cond_b, cond_c;
	logic [DATA_W-1:0]   cap_data;
	logic                node_we, weak_we, paddr_we, peer_we;
	logic [SER_W-1:0]    rd_serial;
	logic [AUTH_W-1:0]   rd_auth;
	logic [ADR_W-1:0]    rd_waddr, rd_paddr;
	logic [KEY_W-1:0]    rd_wkey, rd_pkey;
	logic [IW-1:0]       rd_nidx;

	// Handshake and scan control.
	assign req_ready  = (state_q == S_IDLE);
	assign accept     = req_valid && req_ready;
	assign scan_issue = (state_q == S_SCAN) && (rd_cnt_q < SCAN_END);
	assign scan_addr  = rd_cnt_q[IW-1:0];
	assign check      = (state_q == S_SCAN) && chk_valid_q;
	assign scan_last  = check && (chk_idx_q == LAST_IDX);
	assign load_rsp   = (state_q == S_DONE) && (!rsp_valid_q || rsp_ready);
	assign all_hit    = hit_a_q && hit_b_q && hit_c_q;

	// The key lookup reads the serial of the referenced node after the scan.
	assign serial_raddr = (state_q == S_FETCH) ? nidx_q : scan_addr;
	assign paddr_waddr  = (op_q == OP_AUTH_LKUP) ? idx_a_q : idx_c_q;

	// Table writes happen in the commit cycle only.
	assign node_we  = (state_q == S_COMMIT) && (op_q == OP_ADD_NODE) && hit_a_q;
	assign weak_we  = (state_q == S_COMMIT) && (op_q == OP_ADD_WEAK) && hit_a_q;
	assign peer_we  = (state_q == S_COMMIT) && (op_q == OP_VALIDATE) && all_hit;
	assign paddr_we = peer_we ||
		((state_q == S_COMMIT) && (op_q == OP_AUTH_LKUP) && hit_a_q);

	pkt_ram #(.WIDTH(SER_W), .DEPTH(ENTRIES)) u_node_serial (
		.clk(clk), .we(node_we), .waddr(idx_a_q), .wdata(sn_q),
		.re(scan_issue || (state_q == S_FETCH)), .raddr(serial_raddr), .rdata(rd_serial)
	);

	pkt_ram #(.WIDTH(AUTH_W), .DEPTH(ENTRIES)) u_node_auth (
		.clk(clk), .we(node_we), .waddr(idx_a_q), .wdata(auth_q),
		.re(scan_issue), .raddr(scan_addr), .rdata(rd_auth)
	);

	pkt_ram #(.WIDTH(ADR_W), .DEPTH(ENTRIES)) u_weak_addr (
		.clk(clk), .we(weak_we), .waddr(idx_a_q), .wdata(addr_q),
		.re(scan_issue), .raddr(scan_addr), .rdata(rd_waddr)
	);

	pkt_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_weak_key (
		.clk(clk), .we(weak_we), .waddr(idx_a_q), .wdata(key_q),
		.re(scan_issue), .raddr(scan_addr), .rdata(rd_wkey)
	);

	pkt_ram #(.WIDTH(ADR_W), .DEPTH(ENTRIES)) u_peer_addr (
		.clk(clk), .we(paddr_we), .waddr(paddr_waddr), .wdata(addr_q),
		.re(scan_issue), .raddr(scan_addr), .rdata(rd_paddr)
	);

	pkt_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_peer_key (
		.clk(clk), .we(peer_we), .waddr(idx_c_q), .wdata(key_q),
		.re(scan_issue), .raddr(scan_addr), .rdata(rd_pkey)
	);

	pkt_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_peer_nidx (
		.clk(clk), .we(peer_we), .waddr(idx_c_q), .wdata(idx_b_q),
		.re(scan_issue), .raddr(scan_addr), .rdata(rd_nidx)
	);

	// Shared compare unit: one entry of every table per cycle.
	always_comb begin
		n_used   = node_used_q[chk_idx_q];
		n_val    = node_val_q[chk_idx_q];
		w_used   = weak_used_q[chk_idx_q];
		p_used   = peer_used_q[chk_idx_q];
		sn_eq    = (rd_serial == sn_q);
		auth_eq  = (rd_auth == auth_q);
		waddr_eq = (rd_waddr == addr_q);
		wkey_eq  = (rd_wkey == key_q);
		paddr_eq = (rd_paddr == addr_q);
		pkey_eq  = (rd_pkey == key_q);
		cond_b   = n_used && !n_val && sn_eq;
		cond_c   = !p_used;
		cap_data = '0;
		unique case (op_q)
			OP_ADD_NODE:  cond_a = !n_used;
			OP_DROP_NODE: cond_a = n_used && sn_eq;
			OP_ADD_WEAK:  cond_a = !w_used;
			OP_DROP_WEAK: cond_a = w_used && waddr_eq;
			OP_AUTH_LKUP: begin
				cond_a   = n_used && auth_eq;
				cap_data = DATA_W'(rd_serial);
			end
			OP_ADDR_LKUP: begin
				// The peer entry wins over the weak entry at the same index.
				cond_a   = (p_used && paddr_eq) || (w_used && waddr_eq);
				cap_data = (p_used && paddr_eq) ? DATA_W'(rd_pkey) : DATA_W'(rd_wkey);
			end
			OP_KEY_LKUP:  cond_a = p_used && pkey_eq;
			OP_VALIDATE:  cond_a = w_used && waddr_eq && wkey_eq;
		endcase
	end

	// Sequencer, scan hits and table flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rd_cnt_q    <= '0;
			chk_valid_q <= 1'b0;
			hit_a_q     <= 1'b0;
			hit_b_q     <= 1'b0;
			hit_c_q     <= 1'b0;
			node_used_q <= '0;
			node_val_q  <= '0;
			weak_used_q <= '0;
			peer_used_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_ready && !load_rsp) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q     <= S_SCAN;
						rd_cnt_q    <= '0;
						chk_valid_q <= 1'b0;
						hit_a_q     <= 1'b0;
						hit_b_q     <= 1'b0;
						hit_c_q     <= 1'b0;
					end
				end
				S_SCAN: begin
					if (scan_issue) begin
						rd_cnt_q <= rd_cnt_q + CW'(1);
					end
					chk_valid_q <= scan_issue;
					if (check && cond_a) begin
						hit_a_q <= 1'b1;
					end
					if (check && (op_q == OP_VALIDATE) && cond_b) begin
						hit_b_q <= 1'b1;
					end
					if (check && (op_q == OP_VALIDATE) && cond_c) begin
						hit_c_q <= 1'b1;
					end
					if (scan_last) begin
						state_q <= (op_q == OP_KEY_LKUP) ? S_FETCH : S_COMMIT;
					end
				end
				S_FETCH: begin
					state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					state_q <= S_DONE;
					unique case (op_q)
						OP_ADD_NODE: begin
							if (hit_a_q) begin
								node_used_q[idx_a_q] <= 1'b1;
								node_val_q[idx_a_q]  <= 1'b0;
							end
						end
						OP_DROP_NODE: begin
							if (hit_a_q) begin
								node_used_q[idx_a_q] <= 1'b0;
							end
						end
						OP_ADD_WEAK: begin
							if (hit_a_q) begin
								weak_used_q[idx_a_q] <= 1'b1;
							end
						end
						OP_DROP_WEAK: begin
							if (hit_a_q) begin
								weak_used_q[idx_a_q] <= 1'b0;
							end
						end
						OP_VALIDATE: begin
							if (all_hit) begin
								weak_used_q[idx_a_q] <= 1'b0;
								node_val_q[idx_b_q]  <= 1'b1;
								peer_used_q[idx_c_q] <= 1'b1;
							end
						end
						OP_AUTH_LKUP, OP_ADDR_LKUP, OP_KEY_LKUP: begin
						end
					endcase
				end
				S_DONE: begin
					if (load_rsp) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
			endcase
		end
	end

	// Captured item, first-match indexes and result data.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op_t'(operation);
			sn_q   <= serial_in[SER_W-1:0];
			auth_q <= {auth_upper, auth_lower};
			key_q  <= key_in[KEY_W-1:0];
			addr_q <= peer_address[ADR_W-1:0];
			data_q <= '0;
		end
		chk_idx_q <= scan_addr;
		if (check && cond_a && !hit_a_q) begin
			idx_a_q <= chk_idx_q;
			data_q  <= cap_data;
			nidx_q  <= rd_nidx;
		end
		if (check && cond_b && !hit_b_q) begin
			idx_b_q <= chk_idx_q;
		end
		if (check && cond_c && !hit_c_q) begin
			idx_c_q <= chk_idx_q;
		end
		// The fetched serial arrives in the commit cycle of a key lookup.
		if ((state_q == S_COMMIT) && (op_q == OP_KEY_LKUP) && hit_a_q) begin
			data_q <= DATA_W'(rd_serial);
		end
		if (load_rsp) begin
			success_q    <= (op_q == OP_VALIDATE) ? all_hit : hit_a_q;
			serial_out_q <= ((op_q == OP_AUTH_LKUP) || (op_q == OP_KEY_LKUP)) ? data_q : '0;
			key_out_q    <= (op_q == OP_ADDR_LKUP) ? data_q : '0;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign success    = success_q;
	assign serial_out = serial_out_q;
	assign key_out    = key_out_q;

endmodule

@@ sv/pkt_ram.sv @@
module pkt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port and one read port with registered read data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ sv/pkt_checker.sv @@
module pkt_checker import pkt_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   req_valid,
	input logic                   req_ready,
	input logic                   rsp_valid,
	input logic                   rsp_ready,
	input logic                   success,
	input logic [DATA_W-1:0]      serial_out,
	input logic [DATA_W-1:0]      key_out
);

	// The block is busy for the whole scan after it takes an item.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while a scan was starting");

	// A failed operation returns no data.
	a_fail_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !success |-> (serial_out == '0) && (key_out == '0))
		else $error("failed item carries data");

	// Only one of the two data fields can be returned by one operation.
	a_one_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (serial_out != '0) |-> (key_out == '0))
		else $error("serial and key returned together");

	// A stalled result holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(success) &&
			$stable(serial_out) && $stable(key_out))
		else $error("stalled result changed");

endmodule

bind peer_key_table_unit pkt_checker u_pkt_checker (.*);

@@ bench/peer_key_table_unit_tb.sv @@
module peer_key_table_unit_tb;
	import pkt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TBL_DEPTH = 16;
	localparam int POOL = 6;
	localparam int RANDOM_ITEMS = 400;
	localparam int HOLD_AT = 150;
	localparam int HOLD_CYCLES = 400;
	localparam int MAX_REPORTS = 10;
	localparam logic [DATA_W-1:0] ALL_ONES = '1;

	typedef struct packed {
		op_t                    op;
		logic [DATA_W-1:0]      serial;
		logic [DATA_W-1:0]      auth_hi;
		logic [DATA_W-1:0]      auth_lo;
		logic [DATA_W-1:0]      key;
		logic [ADDR_PORT_W-1:0] addr;
	} table_cmd_t;

	typedef struct packed {
		logic              ok;
		logic [DATA_W-1:0] serial;
		logic [DATA_W-1:0] key;
	} table_result_t;

	typedef struct packed {
		table_cmd_t    cmd;
		logic          typed;
		table_result_t rsp;
	} directed_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   req_valid = 1'b0;
	logic                   req_ready;
	logic [OP_W-1:0]        operation = '0;
	logic [DATA_W-1:0]      serial_in = '0;
	logic [DATA_W-1:0]      auth_upper = '0;
	logic [DATA_W-1:0]      auth_lower = '0;
	logic [DATA_W-1:0]      key_in = '0;
	logic [ADDR_PORT_W-1:0] peer_address = '0;
	logic                   rsp_valid;
	logic                   rsp_ready = 1'b0;
	logic                   success;
	logic [DATA_W-1:0]      serial_out;
	logic [DATA_W-1:0]      key_out;

	// Shadow copy of the three tables; everything starts free and zero.
	bit                   known_used    [TBL_DEPTH];
	bit                   known_checked [TBL_DEPTH];
	bit [DATA_W-1:0]      known_serial  [TBL_DEPTH];
	bit [DATA_W-1:0]      known_auth_hi [TBL_DEPTH];
	bit [DATA_W-1:0]      known_auth_lo [TBL_DEPTH];
	bit                   weak_used     [TBL_DEPTH];
	bit [ADDR_PORT_W-1:0] weak_addr     [TBL_DEPTH];
	bit [DATA_W-1:0]      weak_key      [TBL_DEPTH];
	bit                   peer_used     [TBL_DEPTH];
	bit [ADDR_PORT_W-1:0] peer_addr     [TBL_DEPTH];
	bit [DATA_W-1:0]      peer_key      [TBL_DEPTH];
	bit [3:0]             peer_node     [TBL_DEPTH];

	// Value pools keep random items likely to hit stored entries.
	logic [DATA_W-1:0]      serial_pool  [POOL];
	logic [DATA_W-1:0]      auth_hi_pool [POOL];
	logic [DATA_W-1:0]      auth_lo_pool [POOL];
	logic [DATA_W-1:0]      key_pool     [POOL];
	logic [ADDR_PORT_W-1:0] addr_pool    [POOL];

	table_result_t pending_results[$];
	directed_row_t directed_q[$];
	int            failures = 0;
	int            offered = 0;
	bit            send_burst = 1'b0;

	peer_key_table_unit dut (.*);

	// Free-running clock.
	initial begin
		forever #4 clk = ~clk;
	end

	// Hard stop in case the handshakes hang.
	initial begin
		#3_000_000;
		$display("status: fail");
		$finish;
	end

	function automatic logic [DATA_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Applies one item to the shadow tables and returns the result it must give.
	function automatic table_result_t apply_to_tables(input table_cmd_t c);
		table_result_t r;
		int wi;
		int nj;
		int pk;
		r = '0;
		wi = -1;
		nj = -1;
		pk = -1;
		case (c.op)
		OP_ADD_NODE: begin
			for (int i = 0; i < TBL_DEPTH; i++) begin
				if (!known_used[i]) begin
					known_used[i] = 1'b1;
					known_checked[i] = 1'b0;
					known_serial[i] = c.serial;
					known_auth_hi[i] = c.auth_hi;
					known_auth_lo[i] = c.auth_lo;
					r.ok = 1'b1;
					break;
				end
			end
		end
		OP_DROP_NODE: begin
			for (int i = 0; i < TBL_DEPTH; i++) begin
				if (known_used[i] && known_serial[i] == c.serial) begin
					known_used[i] = 1'b0;
					r.ok = 1'b1;
					break;
				end
			end
		end
		OP_ADD_WEAK: begin
			for (int i = 0; i < TBL_DEPTH; i++) begin
				if (!weak_used[i]) begin
					weak_used[i] = 1'b1;
					weak_addr[i] = c.addr;
					weak_key[i] = c.key;
					r.ok = 1'b1;
					break;
				end
			end
		end
		OP_DROP_WEAK: begin
			for (int i = 0; i < TBL_DEPTH; i++) begin
				if (weak_used[i] && weak_addr[i] == c.addr) begin
					weak_used[i] = 1'b0;
					r.ok = 1'b1;
					break;
				end
			end
		end
		OP_AUTH_LKUP: begin
			// The address lands in the peer slot of the same index, used or not.
			for (int i = 0; i < TBL_DEPTH; i++) begin
				if (known_used[i] && known_auth_hi[i] == c.auth_hi &&
						known_auth_lo[i] == c.auth_lo) begin
					r.serial = known_serial[i];
					peer_addr[i] = c.addr;
					r.ok = 1'b1;
					break;
				end
			end
		end
		OP_ADDR_LKUP: begin
			// At each index the peer entry wins over the weak entry.
			for (int i = 0; i < TBL_DEPTH; i++) begin
				if (peer_used[i] && peer_addr[i] == c.addr) begin
					r.key = peer_key[i];
					r.ok = 1'b1;
					break;
				end
				if (weak_used[i] && weak_addr[i] == c.addr) begin
					r.key = weak_key[i];
					r.ok = 1'b1;
					break;
				end
			end
		end
		OP_KEY_LKUP: begin
			// A dropped node still supplies its stored serial.
			for (int i = 0; i < TBL_DEPTH; i++) begin
				if (peer_used[i] && peer_key[i] == c.key) begin
					r.serial = known_serial[peer_node[i]];
					r.ok = 1'b1;
					break;
				end
			end
		end
		OP_VALIDATE: begin
			for (int i = 0; i < TBL_DEPTH && wi < 0; i++)
				if (weak_used[i] && weak_addr[i] == c.addr && weak_key[i] == c.key)
					wi = i;
			for (int j = 0; j < TBL_DEPTH && nj < 0; j++)
				if (known_used[j] && !known_checked[j] && known_serial[j] == c.serial)
					nj = j;
			for (int k = 0; k < TBL_DEPTH && pk < 0; k++)
				if (!peer_used[k])
					pk = k;
			if (wi >= 0 && nj >= 0 && pk >= 0) begin
				peer_used[pk] = 1'b1;
				peer_addr[pk] = c.addr;
				peer_key[pk] = c.key;
				peer_node[pk] = nj[3:0];
				weak_used[wi] = 1'b0;
				known_checked[nj] = 1'b1;
				r.ok = 1'b1;
			end
		end
		default: begin
		end
		endcase
		return r;
	endfunction

	// Builds an item from the pools, with an occasional field replaced by noise.
	function automatic table_cmd_t pool_cmd(input op_t op, input int k, input int a);
		table_cmd_t c;
		c.op = op;
		c.serial = ($urandom_range(0, 7) == 0) ? rand64() : serial_pool[k];
		c.auth_hi = ($urandom_range(0, 7) == 0) ? rand64() : auth_hi_pool[k];
		c.auth_lo = ($urandom_range(0, 7) == 0) ? rand64() : auth_lo_pool[k];
		c.key = ($urandom_range(0, 7) == 0) ? rand64() : key_pool[a];
		c.addr = ($urandom_range(0, 7) == 0) ? ADDR_PORT_W'($urandom) : addr_pool[a];
		return c;
	endfunction

	task automatic add_row(input op_t op, input logic [DATA_W-1:0] sn,
			input logic [DATA_W-1:0] au, input logic [DATA_W-1:0] al,
			input logic [DATA_W-1:0] key, input logic [ADDR_PORT_W-1:0] addr,
			input logic typed, input logic ok, input logic [DATA_W-1:0] sn_o,
			input logic [DATA_W-1:0] key_o);
		directed_row_t row;
		row.cmd = '{op, sn, au, al, key, addr};
		row.typed = typed;
		row.rsp = '{ok, sn_o, key_o};
		directed_q.push_back(row);
	endtask

	// Offers one item after a random gap and records its expected result on acceptance.
	task automatic offer_item(input table_cmd_t c, input logic typed,
			input table_result_t typed_rsp);
		int gap;
		table_result_t predicted;
		if (offered % 40 == 0)
			send_burst = ($urandom_range(0, 2) == 0);
		gap = send_burst ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		operation <= c.op;
		serial_in <= c.serial;
		auth_upper <= c.auth_hi;
		auth_lower <= c.auth_lo;
		key_in <= c.key;
		peer_address <= c.addr;
		do @(posedge clk); while (!req_ready);
		predicted = apply_to_tables(c);
		pending_results.push_back(typed ? typed_rsp : predicted);
		offered++;
	endtask

	// Stimulus: reset, the directed table, then random items.
	initial begin
		table_cmd_t c;
		table_cmd_t session_q[$];
		int mode;
		int k;
		int a;
		op_t op;
		mode = 0;
		for (int i = 0; i < POOL; i++) begin
			serial_pool[i] = rand64();
			auth_hi_pool[i] = rand64();
			auth_lo_pool[i] = rand64();
			key_pool[i] = rand64();
			addr_pool[i] = ADDR_PORT_W'($urandom);
		end
		serial_pool[0] = ALL_ONES;
		auth_hi_pool[0] = ALL_ONES;
		auth_lo_pool[0] = ALL_ONES;
		key_pool[0] = ALL_ONES;
		addr_pool[0] = '1;
		serial_pool[1] = '0;
		auth_hi_pool[1] = '0;
		auth_lo_pool[1] = '0;
		key_pool[1] = '0;
		addr_pool[1] = '0;

		// Every table is empty after reset, so every search fails.
		add_row(OP_AUTH_LKUP, 0, 0, 0, 0, 16'h0000, 1, 0, 0, 0);
		add_row(OP_ADDR_LKUP, 0, 0, 0, 0, 16'h0000, 1, 0, 0, 0);
		add_row(OP_KEY_LKUP, 0, 0, 0, 0, 16'h0000, 1, 0, 0, 0);
		add_row(OP_DROP_NODE, 0, 0, 0, 0, 16'h0000, 1, 0, 0, 0);
		add_row(OP_DROP_WEAK, 0, 0, 0, 0, 16'h0000, 1, 0, 0, 0);
		add_row(OP_VALIDATE, 0, 0, 0, 0, 16'h0000, 1, 0, 0, 0);
		// Extremes of the fields, then a full validate round trip.
		add_row(OP_ADD_NODE, ALL_ONES, ALL_ONES, ALL_ONES, 0, 16'h0000, 1, 1, 0, 0);
		add_row(OP_ADD_NODE, 0, 0, 0, ALL_ONES, 16'hFFFF, 1, 1, 0, 0);
		add_row(OP_AUTH_LKUP, 0, ALL_ONES, ALL_ONES, 0, 16'hABCD, 1, 1, ALL_ONES, 0);
		add_row(OP_AUTH_LKUP, 0, ALL_ONES, 0, 0, 16'h0000, 1, 0, 0, 0);
		add_row(OP_ADD_WEAK, 0, 0, 0, ALL_ONES, 16'hFFFF, 1, 1, 0, 0);
		add_row(OP_ADD_WEAK, 0, 0, 0, 64'h5A5A_A5A5_0F0F_F0F0, 16'hFFFF, 1, 1, 0, 0);
		add_row(OP_VALIDATE, ALL_ONES, 0, 0, 0, 16'hFFFF, 1, 0, 0, 0);
		add_row(OP_VALIDATE, ALL_ONES, 0, 0, ALL_ONES, 16'hFFFF, 1, 1, 0, 0);
		add_row(OP_ADDR_LKUP, 0, 0, 0, 0, 16'hFFFF, 1, 1, 0, ALL_ONES);
		add_row(OP_VALIDATE, ALL_ONES, 0, 0, ALL_ONES, 16'hFFFF, 1, 0, 0, 0);
		add_row(OP_KEY_LKUP, 0, 0, 0, ALL_ONES, 16'h0000, 1, 1, ALL_ONES, 0);
		add_row(OP_DROP_NODE, ALL_ONES, 0, 0, 0, 16'h0000, 1, 1, 0, 0);
		// A peer whose node was dropped, then whose slot was refilled.
		add_row(OP_KEY_LKUP, 0, 0, 0, ALL_ONES, 16'h0000, 0, 0, 0, 0);
		add_row(OP_ADD_NODE, 64'h0123_4567_89AB_CDEF, 64'h5555_5555_5555_5555,
			64'hAAAA_AAAA_AAAA_AAAA, 0, 16'h0000, 0, 0, 0, 0);
		add_row(OP_KEY_LKUP, 0, 0, 0, ALL_ONES, 16'h0000, 0, 0, 0, 0);
		// An authenticator search rewrites the address of the peer slot at its index.
		add_row(OP_AUTH_LKUP, 0, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 0,
			16'h7777, 0, 0, 0, 0);
		add_row(OP_ADDR_LKUP, 0, 0, 0, 0, 16'h7777, 0, 0, 0, 0);
		add_row(OP_AUTH_LKUP, 0, 0, 0, 0, 16'h0001, 0, 0, 0, 0);
		add_row(OP_ADDR_LKUP, 0, 0, 0, 0, 16'h0001, 0, 0, 0, 0);
		add_row(OP_DROP_WEAK, 0, 0, 0, 64'h1234, 16'hFFFF, 0, 0, 0, 0);
		add_row(OP_ADDR_LKUP, 0, 0, 0, 0, 16'hFFFF, 0, 0, 0, 0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_q[i])
			offer_item(directed_q[i].cmd, directed_q[i].typed, directed_q[i].rsp);

		// Random part: balanced, filling, draining, and scripted peer sessions.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 50 == 0)
				mode = $urandom_range(0, 3);
			k = $urandom_range(0, POOL - 1);
			a = $urandom_range(0, POOL - 1);
			op = op_t'($urandom_range(0, 7));
			if (mode == 3) begin
				if (session_q.size() == 0) begin
					session_q.push_back(pool_cmd(OP_ADD_NODE, k, a));
					session_q.push_back(pool_cmd(OP_ADD_WEAK, k, a));
					session_q.push_back(pool_cmd(OP_VALIDATE, k, a));
					session_q.push_back(pool_cmd(OP_AUTH_LKUP, k, a));
					session_q.push_back(pool_cmd(OP_ADDR_LKUP, k, a));
					session_q.push_back(pool_cmd(OP_KEY_LKUP, k, a));
				end
				c = session_q.pop_front();
			end else begin
				if (mode == 1 && $urandom_range(0, 1) == 1)
					op = ($urandom_range(0, 1) == 1) ? OP_ADD_NODE : OP_ADD_WEAK;
				else if (mode == 2 && $urandom_range(0, 1) == 1)
					op = ($urandom_range(0, 1) == 1) ? OP_DROP_NODE : OP_DROP_WEAK;
				c = pool_cmd(op, k, a);
			end
			offer_item(c, 1'b0, '0);
		end
		req_valid <= 1'b0;

		// Drain, then allow a few more item times for stray results.
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (3 * TBL_DEPTH) @(posedge clk);
		if (failures == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Response side: random stalls, one long hold-off, and the result check.
	initial begin
		int stall;
		int taken;
		bit late;
		bit burst;
		table_result_t want;
		taken = 0;
		burst = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (taken % 40 == 0)
				burst = ($urandom_range(0, 2) == 0);
			stall = burst ? 0 : $urandom_range(0, 13);
			if (taken == HOLD_AT)
				stall = HOLD_CYCLES;
			late = $urandom_range(0, 1);
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				// Either count from now or from the moment a result shows up.
				if (late)
					do @(posedge clk); while (!rsp_valid);
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
			if (pending_results.size() == 0) begin
				failures++;
				if (failures <= MAX_REPORTS)
					$display("unexpected result: success %0b serial %h key %h",
						success, serial_out, key_out);
			end else begin
				want = pending_results.pop_front();
				if (success !== want.ok || serial_out !== want.serial ||
						key_out !== want.key) begin
					failures++;
					if (failures <= MAX_REPORTS)
						$display("result %0d mismatch: success %0b/%0b serial %h/%h key %h/%h (expected/actual)",
							taken, want.ok, success, want.serial, serial_out,
							want.key, key_out);
				end
			end
			taken++;
		end
	end

endmodule
